// ===== design/mfpq_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package mfpq_pkg;

  localparam int CAPACITY_DEF = 64;
  localparam int LEVELS_DEF   = 16;
  localparam int ID_BITS_DEF  = 16;

  localparam int KIND_W   = 2;
  localparam int FID_W    = 16;
  localparam int LV_W     = 4;
  localparam int STATUS_W = 3;
  localparam int STAMP_W  = 32;

  typedef enum logic [KIND_W-1:0] {
    KIND_ENQ = 2'd0,
    KIND_DEQ = 2'd1,
    KIND_REM = 2'd2,
    KIND_CHG = 2'd3
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_DUP      = 3'd1,
    ST_NOTFOUND = 3'd2,
    ST_EMPTY    = 3'd3,
    ST_SAME     = 3'd4,
    ST_FULL     = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_DONE
  } state_t;

  typedef struct packed {
    kind_t            kind;
    logic [FID_W-1:0] entry_id;
    logic [LV_W-1:0]  level;
  } in_t;

  typedef struct packed {
    status_t          status;
    logic [FID_W-1:0] out_id;
    logic [LV_W-1:0]  out_level;
  } out_t;

  // per-slot verdict of the compare unit
  typedef struct packed {
    logic id_hit;
    logic free;
    logic better;
  } hit_t;

endpackage

`default_nettype wire

// ===== design/multilevel_fifo_priority_queue_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel   Ports                              Moves
// in        in_valid, in_ready, in_data        one operation (kind, entry_id, level)
// out       out_valid, out_ready, out_data     one result (status, out_id, out_level)
//
// Each operation reads the slot table one slot per cycle through a single
// compare unit, in the steps accept, scan of every slot, drain and update.
// rst_n is synchronous; after reset a clearing pass over the table marks
// every slot free, and in_ready stays low until it finishes.
// The result register frees the engine; a stalled out_ready holds the
// update cycle until the previous result is taken.

module multilevel_fifo_priority_queue_core import mfpq_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF,
  parameter int LEVELS   = LEVELS_DEF,
  parameter int ID_BITS  = ID_BITS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  localparam int IDX_W  = $clog2(CAPACITY);
  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int ID_W   = (ID_BITS < FID_W) ? ID_BITS : FID_W;
  localparam int LV_MAX = (LEVELS > (1 << LV_W)) ? ((1 << LV_W) - 1) : (LEVELS - 1);

  // slot table
  logic               mem_vld   [CAPACITY];
  logic [ID_W-1:0]    mem_id    [CAPACITY];
  logic [LV_W-1:0]    mem_lv    [CAPACITY];
  logic [STAMP_W-1:0] mem_stamp [CAPACITY];

  logic               rd_vld_q;
  logic [ID_W-1:0]    rd_id_q;
  logic [LV_W-1:0]    rd_lv_q;
  logic [STAMP_W-1:0] rd_stamp_q;

  logic               wr_en;
  logic [IDX_W-1:0]   wr_addr;
  logic               wr_vld;
  logic [LV_W-1:0]    wr_lv;

  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               pend_r, pend_nxt;
  logic [IDX_W-1:0]   pend_idx_r;
  logic [STAMP_W-1:0] counter_r, counter_nxt;
  logic               found_r, found_nxt;
  logic               free_have_r, free_have_nxt;
  logic               out_valid_r, out_valid_nxt;

  kind_t              kind_r;
  logic [ID_W-1:0]    id_r;
  logic [LV_W-1:0]    lv_r;
  logic [IDX_W-1:0]   found_idx_r, free_idx_r;
  logic [LV_W-1:0]    found_lv_r;
  logic [ID_W-1:0]    found_id_r;
  logic [STAMP_W-1:0] best_age_r;
  out_t               out_data_r, res;

  hit_t               hit;
  logic [STAMP_W-1:0] age;
  logic               take, take_free, accept, done_go;
  logic [LV_W-1:0]    lv_in;

  assign in_ready  = (state_r == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign done_go   = (state_r == S_DONE) && (!out_valid_r || out_ready);
  assign lv_in     = (in_data.level > LV_W'(LV_MAX)) ? LV_W'(LV_MAX) : in_data.level;

  mfpq_match #(
    .ID_W(ID_W)
  ) u_match (
    .slot_vld  (rd_vld_q),
    .slot_id   (rd_id_q),
    .slot_lv   (rd_lv_q),
    .slot_stamp(rd_stamp_q),
    .key_id    (id_r),
    .arrival   (counter_r),
    .best_have (found_r),
    .best_lv   (found_lv_r),
    .best_age  (best_age_r),
    .hit       (hit),
    .age       (age)
  );

  // dequeue keeps the best so far; the id searches keep the first hit
  assign take      = pend_r && ((kind_r == KIND_DEQ) ? hit.better : (hit.id_hit && !found_r));
  assign take_free = pend_r && hit.free && !free_have_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_vld[wr_addr]   <= wr_vld;
      mem_id[wr_addr]    <= id_r;
      mem_lv[wr_addr]    <= wr_lv;
      mem_stamp[wr_addr] <= counter_r;
    end
    rd_vld_q   <= mem_vld[cnt_r[IDX_W-1:0]];
    rd_id_q    <= mem_id[cnt_r[IDX_W-1:0]];
    rd_lv_q    <= mem_lv[cnt_r[IDX_W-1:0]];
    rd_stamp_q <= mem_stamp[cnt_r[IDX_W-1:0]];
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    pend_nxt      = 1'b0;
    counter_nxt   = counter_r;
    found_nxt     = found_r || take;
    free_have_nxt = free_have_r || take_free;
    out_valid_nxt = out_valid_r && !out_ready;
    wr_en         = 1'b0;
    wr_addr       = cnt_r[IDX_W-1:0];
    wr_vld        = 1'b0;
    wr_lv         = lv_r;
    res.status    = ST_OK;
    res.out_id    = '0;
    res.out_level = '0;

    // result of the finished search
    unique case (kind_r)
      KIND_ENQ: begin
        if (found_r) begin
          res.status    = ST_DUP;
          res.out_id    = FID_W'(id_r);
          res.out_level = found_lv_r;
        end else if (!free_have_r) begin
          res.status = ST_FULL;
        end else begin
          res.out_id    = FID_W'(id_r);
          res.out_level = lv_r;
        end
      end
      KIND_DEQ: begin
        if (!found_r) begin
          res.status = ST_EMPTY;
        end else begin
          res.out_id    = FID_W'(found_id_r);
          res.out_level = found_lv_r;
        end
      end
      KIND_REM, KIND_CHG: begin
        if (!found_r) begin
          res.status = ST_NOTFOUND;
        end else begin
          res.out_id    = FID_W'(id_r);
          res.out_level = found_lv_r;
          if (kind_r == KIND_CHG && found_lv_r == lv_r) begin
            res.status = ST_SAME;
          end
        end
      end
      default: res.status = ST_OK;
    endcase

    unique case (state_r)
      S_CLEAR: begin
        wr_en = 1'b1;
        if (cnt_r == CNT_W'(CAPACITY - 1)) begin
          state_nxt = S_IDLE;
        end
        cnt_nxt = cnt_r + 1'b1;
      end
      S_IDLE: begin
        if (accept) begin
          cnt_nxt       = '0;
          found_nxt     = 1'b0;
          free_have_nxt = 1'b0;
          state_nxt     = S_SCAN;
        end
      end
      S_SCAN: begin
        pend_nxt = 1'b1;
        if (cnt_r == CNT_W'(CAPACITY - 1)) begin
          state_nxt = S_DRAIN;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_DRAIN: begin
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (done_go) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
          unique case (kind_r)
            KIND_ENQ: begin
              if (!found_r && free_have_r) begin
                wr_en       = 1'b1;
                wr_addr     = free_idx_r;
                wr_vld      = 1'b1;
                counter_nxt = counter_r + 1'b1;
              end
            end
            KIND_DEQ, KIND_REM: begin
              // drop the entry
              wr_en   = found_r;
              wr_addr = found_idx_r;
            end
            KIND_CHG: begin
              // move to the tail of the new level
              if (found_r && found_lv_r != lv_r) begin
                wr_en       = 1'b1;
                wr_addr     = found_idx_r;
                wr_vld      = 1'b1;
                counter_nxt = counter_r + 1'b1;
              end
            end
            default: wr_en = 1'b0;
          endcase
        end
      end
      default: state_nxt = S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      cnt_r       <= '0;
      pend_r      <= 1'b0;
      counter_r   <= '0;
      found_r     <= 1'b0;
      free_have_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      pend_r      <= pend_nxt;
      counter_r   <= counter_nxt;
      found_r     <= found_nxt;
      free_have_r <= free_have_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_idx_r <= cnt_r[IDX_W-1:0];
    if (accept) begin
      kind_r <= in_data.kind;
      id_r   <= in_data.entry_id[ID_W-1:0];
      lv_r   <= lv_in;
    end
    if (take) begin
      found_idx_r <= pend_idx_r;
      found_lv_r  <= rd_lv_q;
      found_id_r  <= rd_id_q;
      best_age_r  <= age;
    end
    if (take_free) begin
      free_idx_r <= pend_idx_r;
    end
    if (done_go) begin
      out_data_r <= res;
    end
  end

`ifndef SYNTHESIS
  a_pend_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> (state_r == S_SCAN || state_r == S_DRAIN))
    else $error("slot data pending outside a scan");

  a_stamp_on_update: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && counter_r != $past(counter_r)) |-> $past(state_r == S_DONE))
    else $error("arrival counter moved outside the update cycle");

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && $rose(out_valid_r)) |-> $past(state_r == S_DONE))
    else $error("result raised outside the update cycle");

  a_found_from_slot: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && $rose(found_r)) |-> $past(pend_r))
    else $error("match flagged without slot data");
`endif

endmodule

`default_nettype wire

// ===== design/mfpq_match.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mfpq_match import mfpq_pkg::*; #(
  parameter int ID_W = ID_BITS_DEF
) (
  input  logic               slot_vld,
  input  logic [ID_W-1:0]    slot_id,
  input  logic [LV_W-1:0]    slot_lv,
  input  logic [STAMP_W-1:0] slot_stamp,
  input  logic [ID_W-1:0]    key_id,
  input  logic [STAMP_W-1:0] arrival,
  input  logic               best_have,
  input  logic [LV_W-1:0]    best_lv,
  input  logic [STAMP_W-1:0] best_age,
  output hit_t               hit,
  output logic [STAMP_W-1:0] age
);

  // age wraps modulo 2^32, same as the stamp counter
  assign age = arrival - slot_stamp;

  always_comb begin
    hit.id_hit = slot_vld && (slot_id == key_id);
    hit.free   = !slot_vld;
    hit.better = slot_vld && (!best_have || (slot_lv > best_lv) ||
                              ((slot_lv == best_lv) && (age > best_age)));
  end

endmodule

`default_nettype wire
